### src/shared_buffer_multi_queue_macros.svh
// Assertion macros for the shared buffer multi-queue.
// Expects signals named clock and reset in the module that uses them.
`ifndef SHARED_BUFFER_MULTI_QUEUE_MACROS_SVH
`define SHARED_BUFFER_MULTI_QUEUE_MACROS_SVH

// Check cons in the same cycle as ante.
`define SBMQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define SBMQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/sbmq_pkg.sv
// Shared types, constants and pointer helpers for the shared buffer multi-queue.
// No dependencies.
`timescale 1ns / 1ps
package sbmq_pkg;

   localparam int NUM_SLOTS  = 64;
   localparam int NUM_QUEUES = 8;

   localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int PTR_W    = $clog2(NUM_SLOTS + 1);
   localparam int QSEL_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int QIN_W    = 3;
   localparam int QEXT_W   = (QSEL_W > QIN_W) ? QSEL_W : QIN_W;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(NUM_SLOTS);

   localparam logic KIND_ENQ = 1'b0;
   localparam logic KIND_DEQ = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic             en;
      logic             we;
      logic [IDX_W-1:0] addr;
      logic [PTR_W-1:0] wdata;
   } link_req_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] wdata;
   } data_req_type;

   function automatic logic ptr_valid(input logic [PTR_W-1:0] p);
      return p < PTR_NULL;
   endfunction

   function automatic logic [IDX_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
      return p[IDX_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] idx_ptr(input logic [IDX_W-1:0] i);
      return PTR_W'(i);
   endfunction

endpackage

### src/sbmq_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sbmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      en,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                          wdata,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/sbmq_link_ram.sv
// Slot link store: single-port RAM with per-entry valid bits so that an
// unwritten entry reads as its reset link (next slot). Uses sbmq_pkg.
`timescale 1ns / 1ps
module sbmq_link_ram (
   input  logic                        clock,
   input  logic                        reset,
   input  sbmq_pkg::link_req_type      req,
   output logic [sbmq_pkg::PTR_W-1:0]  rdata
);
   import sbmq_pkg::*;

   logic [PTR_W-1:0]     mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [PTR_W-1:0]     rdata_ff;
   logic                 rvalid_ff;
   logic [IDX_W-1:0]     raddr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.en && req.we) begin
         valid_ff[req.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req.en) begin
         if (req.we) begin
            mem[req.addr] <= req.wdata;
         end else begin
            rdata_ff  <= mem[req.addr];
            rvalid_ff <= valid_ff[req.addr];
            raddr_ff  <= req.addr;
         end
      end
   end

   // untouched entry i links to i+1; the last one lands on null
   assign rdata = rvalid_ff ? rdata_ff : (idx_ptr(raddr_ff) + PTR_W'(1));

endmodule

### src/sbmq_ctrl.sv
// Queue sequencer: head/tail/free pointers and the read-modify-write of the
// link and data stores. Uses sbmq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "shared_buffer_multi_queue_macros.svh"
module sbmq_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_kind,
   input  logic [sbmq_pkg::QIN_W-1:0]            req_queue_index,
   input  logic [sbmq_pkg::DATA_W-1:0]           req_value,
   output sbmq_pkg::link_req_type                link_req,
   input  logic [sbmq_pkg::PTR_W-1:0]            link_rdata,
   output sbmq_pkg::data_req_type                data_req,
   input  logic [sbmq_pkg::DATA_W-1:0]           data_rdata,
   output logic                                  rsp_valid,
   output logic [sbmq_pkg::DATA_W-1:0]           rsp_read_value,
   output logic [sbmq_pkg::STATUS_W-1:0]         rsp_status
);
   import sbmq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LINK = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                kind_ff, kind_in;
   logic [QSEL_W-1:0]   q_ff, q_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [PTR_W-1:0]    free_head_ff, free_head_in;
   logic [PTR_W-1:0]    queue_head_ff [NUM_QUEUES];
   logic [PTR_W-1:0]    queue_head_in [NUM_QUEUES];
   logic [PTR_W-1:0]    queue_tail_ff [NUM_QUEUES];
   logic [PTR_W-1:0]    queue_tail_in [NUM_QUEUES];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_read_value_ff, rsp_read_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [QEXT_W-1:0]   q_ext;
   logic [QSEL_W-1:0]   q_sel;
   logic                q_exists;
   logic [PTR_W-1:0]    head_req;

   assign q_ext    = QEXT_W'(req_queue_index);
   assign q_sel    = q_ext[QSEL_W-1:0];
   assign q_exists = {1'b0, q_ext} < (QEXT_W + 1)'(NUM_QUEUES);
   assign head_req = queue_head_ff[q_sel];

   always_comb begin
      state_in          = state_ff;
      kind_in           = kind_ff;
      q_in              = q_ff;
      value_in          = value_ff;
      slot_in           = slot_ff;
      tail_in           = tail_ff;
      free_head_in      = free_head_ff;
      queue_head_in     = queue_head_ff;
      queue_tail_in     = queue_tail_ff;
      rsp_valid_in      = 1'b0;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_status_in     = rsp_status_ff;
      link_req          = '0;
      data_req          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               q_in     = q_sel;
               value_in = req_value;
               if (req_kind == KIND_ENQ) begin
                  if (!q_exists || !ptr_valid(free_head_ff)) begin
                     rsp_valid_in      = 1'b1;
                     rsp_read_value_in = '0;
                     rsp_status_in     = STATUS_OVERFLOW;
                  end else begin
                     slot_in       = ptr_idx(free_head_ff);
                     link_req.en   = 1'b1;
                     link_req.addr = ptr_idx(free_head_ff);
                     state_in      = ST_EXEC;
                  end
               end else begin
                  if (!q_exists || !ptr_valid(head_req)) begin
                     rsp_valid_in      = 1'b1;
                     rsp_read_value_in = '0;
                     rsp_status_in     = STATUS_UNDERFLOW;
                  end else begin
                     slot_in       = ptr_idx(head_req);
                     link_req.en   = 1'b1;
                     link_req.addr = ptr_idx(head_req);
                     data_req.en   = 1'b1;
                     data_req.addr = ptr_idx(head_req);
                     state_in      = ST_EXEC;
                  end
               end
            end
         end
         ST_EXEC: begin
            if (kind_ff == KIND_ENQ) begin
               free_head_in          = link_rdata;
               link_req.en           = 1'b1;
               link_req.we           = 1'b1;
               link_req.addr         = slot_ff;
               link_req.wdata        = PTR_NULL;
               data_req.en           = 1'b1;
               data_req.we           = 1'b1;
               data_req.addr         = slot_ff;
               data_req.wdata        = value_ff;
               tail_in               = ptr_idx(queue_tail_ff[q_ff]);
               queue_tail_in[q_ff]   = idx_ptr(slot_ff);
               rsp_read_value_in     = '0;
               rsp_status_in         = STATUS_OK;
               if (!ptr_valid(queue_head_ff[q_ff])) begin
                  queue_head_in[q_ff] = idx_ptr(slot_ff);
                  rsp_valid_in        = 1'b1;
                  state_in            = ST_IDLE;
               end else if (ptr_valid(queue_tail_ff[q_ff])) begin
                  state_in            = ST_LINK;
               end else begin
                  rsp_valid_in        = 1'b1;
                  state_in            = ST_IDLE;
               end
            end else begin
               queue_head_in[q_ff] = link_rdata;
               link_req.en         = 1'b1;
               link_req.we         = 1'b1;
               link_req.addr       = slot_ff;
               link_req.wdata      = free_head_ff;
               free_head_in        = idx_ptr(slot_ff);
               rsp_valid_in        = 1'b1;
               rsp_read_value_in   = data_rdata;
               rsp_status_in       = STATUS_OK;
               state_in            = ST_IDLE;
            end
         end
         ST_LINK: begin
            link_req.en    = 1'b1;
            link_req.we    = 1'b1;
            link_req.addr  = tail_ff;
            link_req.wdata = idx_ptr(slot_ff);
            rsp_valid_in   = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            queue_head_ff[i] <= PTR_NULL;
            queue_tail_ff[i] <= PTR_NULL;
         end
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         rsp_valid_ff  <= rsp_valid_in;
         queue_head_ff <= queue_head_in;
         queue_tail_ff <= queue_tail_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff           <= kind_in;
      q_ff              <= q_in;
      value_ff          <= value_in;
      slot_ff           <= slot_in;
      tail_ff           <= tail_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign busy           = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;

   `SBMQ_ASSERT_NEXT(a_link_done, state_ff == ST_LINK,
                     rsp_valid_ff && state_ff == ST_IDLE,
                     "tail link write did not finish the transfer")
   `SBMQ_ASSERT_NOW(a_err_zero, rsp_valid_ff && rsp_status_ff != STATUS_OK,
                    rsp_read_value_ff == '0,
                    "error result carries data")
   `SBMQ_ASSERT_NOW(a_exec_entry, state_ff == ST_EXEC,
                    $past(state_ff) == ST_IDLE && $past(start),
                    "execute step without accepted transfer")
   `SBMQ_ASSERT_NEXT(a_deq_done, state_ff == ST_EXEC && kind_ff == KIND_DEQ,
                     rsp_valid_ff && rsp_status_ff == STATUS_OK,
                     "dequeue did not complete")

endmodule

### src/shared_buffer_multi_queue.sv
// Several FIFO queues sharing one slot store through a linked free list.
// A request is taken when start is high and busy is low. Overflow, underflow
// and requests to a nonexistent queue are answered in the idle state, busy
// staying low; a dequeue or an enqueue into an empty queue holds busy for
// the execute step, an enqueue behind an existing tail for the execute and
// link steps, as the single port of the link memory takes a read, then one
// write per link changed. Every result appears on rsp_* for exactly one
// cycle with rsp_valid high, in the cycle after the request finishes, and
// cannot be held off, so capture it on that cycle. No clearing pass runs
// after reset. Depends on sbmq_pkg, sbmq_ctrl, sbmq_link_ram and sbmq_ram.
`timescale 1ns / 1ps
module shared_buffer_multi_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_kind,
   input  logic [sbmq_pkg::QIN_W-1:0]           req_queue_index,
   input  logic signed [sbmq_pkg::DATA_W-1:0]   req_value,
   output logic                                 rsp_valid,
   output logic signed [sbmq_pkg::DATA_W-1:0]   rsp_read_value,
   output logic [sbmq_pkg::STATUS_W-1:0]        rsp_status
);
   import sbmq_pkg::*;

   link_req_type      link_req;
   data_req_type      data_req;
   logic [PTR_W-1:0]  link_rdata;
   logic [DATA_W-1:0] data_rdata;
   logic [DATA_W-1:0] read_value;

   sbmq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_queue_index (req_queue_index),
      .req_value       ($unsigned(req_value)),
      .link_req        (link_req),
      .link_rdata      (link_rdata),
      .data_req        (data_req),
      .data_rdata      (data_rdata),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (read_value),
      .rsp_status      (rsp_status)
   );

   sbmq_link_ram u_link_ram (
      .clock (clock),
      .reset (reset),
      .req   (link_req),
      .rdata (link_rdata)
   );

   sbmq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NUM_SLOTS)
   ) u_data_ram (
      .clock (clock),
      .en    (data_req.en),
      .we    (data_req.we),
      .addr  (data_req.addr),
      .wdata (data_req.wdata),
      .rdata (data_rdata)
   );

   assign rsp_read_value = $signed(read_value);

endmodule

### tb/testbench.sv
// Self-checking testbench for shared_buffer_multi_queue: directed table, then biased
// random enqueue/dequeue traffic checked against an in-bench linked-list predictor.
// Depends on sbmq_pkg and the shared_buffer_multi_queue RTL.
`timescale 1ns / 1ps
module testbench;
   import sbmq_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SEGMENTS     = 16;
   localparam int SEGMENT_ITEMS = 100;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

   typedef struct packed {
      logic                kind;
      logic [QIN_W-1:0]    queue_index;
      logic [DATA_W-1:0]   value;
      bit                  typed;
      logic [DATA_W-1:0]   want_value;
      logic [STATUS_W-1:0] want_status;
   } dir_row_type;

   dir_row_type directed_rows [0:22] = '{
      '{KIND_DEQ, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_UNDERFLOW},
      '{KIND_DEQ, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STATUS_UNDERFLOW},
      '{KIND_ENQ, 3'd0, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, STATUS_OK},
      '{KIND_ENQ, 3'd0, 32'h8000_0000, 1'b1, 32'h0000_0000, STATUS_OK},
      '{KIND_ENQ, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STATUS_OK},
      '{KIND_ENQ, 3'd7, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_OK},
      '{KIND_DEQ, 3'd0, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, STATUS_OK},
      '{KIND_DEQ, 3'd7, 32'h5555_5555, 1'b1, 32'hFFFF_FFFF, STATUS_OK},
      '{KIND_DEQ, 3'd0, 32'hAAAA_AAAA, 1'b1, 32'h8000_0000, STATUS_OK},
      '{KIND_DEQ, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_UNDERFLOW},
      '{KIND_ENQ, 3'd0, 32'h1234_5678, 1'b0, 32'h0000_0000, STATUS_OK},
      '{KIND_ENQ, 3'd0, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000, STATUS_OK},
      '{KIND_DEQ, 3'd7, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK},
      '{KIND_DEQ, 3'd7, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK},
      '{KIND_ENQ, 3'd3, 32'hA5A5_A5A5, 1'b0, 32'h0000_0000, STATUS_OK},
      '{KIND_ENQ, 3'd5, 32'h0000_0001, 1'b0, 32'h0000_0000, STATUS_OK},
      '{KIND_DEQ, 3'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK},
      '{KIND_ENQ, 3'd3, 32'h0F0F_0F0F, 1'b0, 32'h0000_0000, STATUS_OK},
      '{KIND_DEQ, 3'd3, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK},
      '{KIND_DEQ, 3'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK},
      '{KIND_DEQ, 3'd5, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK},
      '{KIND_DEQ, 3'd3, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK},
      '{KIND_DEQ, 3'd3, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK}
   };

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_kind = KIND_ENQ;
   logic [QIN_W-1:0]           req_queue_index = '0;
   logic signed [DATA_W-1:0]   req_value = '0;
   logic                       rsp_valid;
   logic signed [DATA_W-1:0]   rsp_read_value;
   logic [STATUS_W-1:0]        rsp_status;

   bit      row_typed = 1'b0;
   rsp_type row_want = '0;

   logic [DATA_W-1:0] slot_value [NUM_SLOTS];
   logic [PTR_W-1:0]  slot_next  [NUM_SLOTS];
   logic [PTR_W-1:0]  q_head     [NUM_QUEUES];
   logic [PTR_W-1:0]  q_tail     [NUM_QUEUES];
   logic [PTR_W-1:0]  free_top;

   rsp_type pending_results [$];
   int   err_count = 0;
   int   cycle_count = 0;
   int   n_enq = 0;
   int   n_deq = 0;
   int   n_over = 0;
   int   n_under = 0;

   shared_buffer_multi_queue dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_queue_index(req_queue_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic rsp_type predict_queue_op(input logic kind,
                                                input logic [QIN_W-1:0] qi,
                                                input logic [DATA_W-1:0] val);
      rsp_type          res;
      logic [PTR_W-1:0] slot;
      res.read_value = '0;
      res.status     = STATUS_OK;
      if (kind == KIND_ENQ) begin
         n_enq++;
         if (int'(qi) >= NUM_QUEUES || free_top >= PTR_NULL) begin
            res.status = STATUS_OVERFLOW;
            n_over++;
         end else begin
            slot = free_top;
            free_top = slot_next[slot[IDX_W-1:0]];
            if (q_head[qi] >= PTR_NULL)
               q_head[qi] = slot;
            else if (q_tail[qi] < PTR_NULL)
               slot_next[q_tail[qi][IDX_W-1:0]] = slot;
            slot_next[slot[IDX_W-1:0]] = PTR_NULL;
            q_tail[qi] = slot;
            slot_value[slot[IDX_W-1:0]] = val;
         end
      end else begin
         n_deq++;
         if (int'(qi) >= NUM_QUEUES || q_head[qi] >= PTR_NULL) begin
            res.status = STATUS_UNDERFLOW;
            n_under++;
         end else begin
            slot = q_head[qi];
            q_head[qi] = slot_next[slot[IDX_W-1:0]];
            slot_next[slot[IDX_W-1:0]] = free_top;
            free_top = slot;
            res.read_value = slot_value[slot[IDX_W-1:0]];
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("testbench: mismatch, %s at cycle %0d: got %h, want %h",
               what, cycle_count, got, want);
      err_count++;
   endtask

   // check the result first, then record the transfer taken at this edge
   always @(posedge clock) begin
      rsp_type want;
      rsp_type predicted;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_read_value, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_read_value !== want.read_value)
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               if (rsp_status !== want.status)
                  report_mismatch("status", DATA_W'(rsp_status), DATA_W'(want.status));
            end
         end
         if (start && !busy) begin
            predicted = predict_queue_op(req_kind, req_queue_index, req_value);
            pending_results.push_back(row_typed ? row_want : predicted);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic send_transfer(input logic kind, input logic [QIN_W-1:0] qi,
                                input logic [DATA_W-1:0] val, input bit typed,
                                input rsp_type want, input int gap_max);
      int gap;
      start           <= 1'b1;
      req_kind        <= kind;
      req_queue_index <= qi;
      req_value       <= val;
      row_typed       <= typed;
      row_want        <= want;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off the sender until every pending result is back
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int   enq_pct;
      int   gap_max;
      logic kind;
      logic [QIN_W-1:0] qi;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_value[i] = '0;
         slot_next[i]  = (i == NUM_SLOTS - 1) ? PTR_NULL : PTR_W'(i + 1);
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
         q_head[i] = PTR_NULL;
         q_tail[i] = PTR_NULL;
      end
      free_top = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_transfer(directed_rows[i].kind, directed_rows[i].queue_index,
                       directed_rows[i].value, directed_rows[i].typed,
                       '{directed_rows[i].want_value, directed_rows[i].want_status}, 3);
      wait_drained();

      // rotate the mix: fill past full, balanced, drain past empty
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 3)
            0:       enq_pct = 85;
            1:       enq_pct = 50;
            default: enq_pct = 20;
         endcase
         gap_max = (seg % 4 == 3) ? 0 : 3;
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
            qi   = (seg % 2 == 1) ? QIN_W'($urandom_range(0, 1))
                                  : QIN_W'($urandom_range(0, NUM_QUEUES - 1));
            send_transfer(kind, qi, pick_value(), 1'b0, '0, gap_max);
         end
         if (seg == SEGMENTS / 2)
            wait_drained();
      end

      wait_drained();
      repeat (8) @(posedge clock);

      $display("testbench: %0d enqueues and %0d dequeues transferred,", n_enq, n_deq);
      $display("testbench: %0d overflows, %0d underflows, %0d mismatches over %0d cycles",
               n_over, n_under, err_count, cycle_count);
      if (err_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

### shared_buffer_multi_queue.f
+incdir+src
src/sbmq_pkg.sv
src/sbmq_ram.sv
src/sbmq_link_ram.sv
src/sbmq_ctrl.sv
src/shared_buffer_multi_queue.sv
tb/testbench.sv
